>>> src/rcf_pkg.sv
`timescale 1ns / 1ps
package rcf_pkg;

  // Fixed-point constants for the exponential
  localparam int unsigned FracBits = 16;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam int unsigned XIntLimit = 12;
  localparam int unsigned XBits = 20;   // x below 12.0 fits in 20 bits

  // 2^(-2^-(i+1)) in Q0.32; entry 0 goes with fraction bit 15
  function automatic logic [31:0] half_power(input logic [3:0] idx);
    logic [31:0] p;
    begin
      case (idx)
        4'd0:  p = 32'd3037000500;
        4'd1:  p = 32'd3611622603;
        4'd2:  p = 32'd3938502376;
        4'd3:  p = 32'd4112874773;
        4'd4:  p = 32'd4202935003;
        4'd5:  p = 32'd4248701965;
        4'd6:  p = 32'd4271771872;
        4'd7:  p = 32'd4283353883;
        4'd8:  p = 32'd4289156659;
        4'd9:  p = 32'd4292060994;
        4'd10: p = 32'd4293513899;
        4'd11: p = 32'd4294240536;
        4'd12: p = 32'd4294603901;
        4'd13: p = 32'd4294785595;
        4'd14: p = 32'd4294876444;
        default: p = 32'd4294921870;
      endcase
      return p;
    end
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic div_start; // restart divider on present elapsed
    logic acc;       // repeated level: grow elapsed, restart divider
    logic seg_new;   // level change: new segment from start point, restart divider
    logic div_step;  // one quotient bit
    logic log_mul;   // y = x * log2(e)
    logic pow_step;  // one fraction bit of 2^-f
    logic e_ld;      // E from the power chain
    logic vmul;      // v = swing * E
    logic out_ld;    // capture output
  } rcf_cmd_t;

  typedef struct packed {
    logic lvl_changed;
  } rcf_sts_t;

endpackage

>>> src/rcf_datapath.sv
`timescale 1ns / 1ps
module rcf_datapath #(
  parameter int SampleBits  = 16,
  parameter int ElapsedBits = 32
) (
  input  logic                         clk,
  input  rcf_pkg::rcf_cmd_t            cmd,
  output rcf_pkg::rcf_sts_t            sts,
  input  logic                         rst_n,
  input  logic [23:0]                  rc_ticks,
  input  logic signed [SampleBits-1:0] in_level,
  input  logic [15:0]                  in_time_step,
  output logic signed [SampleBits-1:0] filtered_level
);
  import rcf_pkg::*;

  localparam int NumW  = ElapsedBits + 16;        // dividend width
  localparam logic [ElapsedBits-1:0] ElapsedMax = '1;
  localparam logic [NumW-1:0] XLimit = NumW'(XIntLimit) << FracBits;

  // Architectural state
  logic signed [SampleBits-1:0] last_level_r, low_level_r, high_level_r;
  logic [SampleBits-1:0]        swing_r;
  logic [ElapsedBits-1:0]       elapsed_r;
  logic                         charging_r;
  logic signed [SampleBits-1:0] lvl_r;
  logic [15:0]                  ts_r;

  // Working registers
  logic [NumW-1:0]  num_r;   // dividend shifting out
  logic [23:0]      rem_r;
  logic [NumW-1:0]  quo_r;
  logic [4:0]       k_r;     // at most 17 below the x limit
  logic [15:0]      f_r;
  logic [3:0]       pidx_r;
  logic [32:0]      m_r;
  logic             zero_r;
  logic [16:0]      e_r;
  logic [SampleBits+16:0] v_r;
  logic signed [SampleBits-1:0] out_r;

  assign sts.lvl_changed = (lvl_r != last_level_r);
  assign filtered_level  = out_r;

  // Restoring divider step
  logic [23:0] rc_eff;
  logic [25:0] rtrial;
  logic [24:0] rsh;
  assign rc_eff = (rc_ticks == 24'd0) ? 24'd1 : rc_ticks;
  assign rsh    = {rem_r, num_r[NumW-1]};
  assign rtrial = {1'b0, rsh} - {2'b00, rc_eff};

  // Power chain multiply
  logic [64:0] pprod;
  assign pprod = m_r * {1'b0, half_power(pidx_r)};

  // Exponential value
  logic [16:0] e_full;
  assign e_full = (zero_r || k_r >= 5'd17) ? '0 : 17'(m_r >> ({1'b0, k_r} + 6'd16));

  // Capacitor value from current segment
  logic [SampleBits-1:0] vv;
  logic signed [SampleBits-1:0] capv;
  assign vv   = v_r[SampleBits+15:16];
  assign capv = charging_r ? high_level_r - $signed(vv) : low_level_r + $signed(vv);

  // New segment bounds, start point is the present capacitor value
  logic signed [SampleBits-1:0] nlo, nhi;
  logic nchg;
  always_comb begin
    if (lvl_r > last_level_r) begin
      nlo = capv; nhi = lvl_r; nchg = 1'b1;
    end else begin
      nhi = capv; nlo = lvl_r; nchg = 1'b0;
    end
    if (nhi < nlo) begin
      {nhi, nlo} = {nlo, nhi};
      nchg = ~nchg;
    end
  end

  // Elapsed growth, saturating
  logic [ElapsedBits:0]   esum;
  logic [ElapsedBits-1:0] eacc;
  assign esum = {1'b0, elapsed_r} + (ElapsedBits + 1)'(ts_r);
  assign eacc = esum[ElapsedBits] ? ElapsedMax : esum[ElapsedBits-1:0];

  logic [XBits+16:0] xy;
  assign xy = quo_r[XBits-1:0] * Log2eQ16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= '0;
      low_level_r  <= '0;
      high_level_r <= '0;
      swing_r      <= '0;
      elapsed_r    <= '0;
      charging_r   <= 1'b0;
      lvl_r        <= '0;
      ts_r         <= '0;
      v_r          <= '0;
      out_r        <= '0;
    end else begin
      if (cmd.load) begin
        lvl_r <= in_level;
        ts_r  <= in_time_step;
      end
      // segment bookkeeping
      if (cmd.seg_new) begin
        low_level_r  <= nlo;
        high_level_r <= nhi;
        charging_r   <= nchg;
        last_level_r <= lvl_r;
        swing_r      <= nhi - nlo;
        elapsed_r    <= ElapsedBits'(ts_r);
      end else if (cmd.acc) begin
        elapsed_r <= eacc;
      end
      // divider: x = (elapsed << 16) / rc
      if (cmd.div_start) begin
        num_r <= NumW'(elapsed_r) << FracBits;
        rem_r <= '0;
        quo_r <= '0;
      end else if (cmd.seg_new) begin
        num_r <= NumW'(ts_r) << FracBits;
        rem_r <= '0;
        quo_r <= '0;
      end else if (cmd.acc) begin
        num_r <= NumW'(eacc) << FracBits;
        rem_r <= '0;
        quo_r <= '0;
      end else if (cmd.div_step) begin
        num_r <= num_r << 1;
        if (!rtrial[25]) begin
          rem_r <= rtrial[23:0];
          quo_r <= {quo_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= rsh[23:0];
          quo_r <= {quo_r[NumW-2:0], 1'b0};
        end
      end
      // x < 12.0 keeps x*log2e below 2^37
      if (cmd.log_mul) begin
        zero_r <= (quo_r >= XLimit);
        k_r    <= xy[XBits+16:32];
        f_r    <= xy[31:16];
        m_r    <= 33'h1_0000_0000;
        pidx_r <= '0;
      end
      if (cmd.pow_step) begin
        if (f_r[15]) m_r <= pprod[64:32];
        f_r    <= {f_r[14:0], 1'b0};
        pidx_r <= pidx_r + 4'd1;
      end
      if (cmd.e_ld) begin
        e_r <= e_full;
      end
      if (cmd.vmul) begin
        v_r <= swing_r * e_r;
      end
      if (cmd.out_ld) begin
        out_r <= capv;
      end
    end
  end
endmodule

>>> src/rcf_ctrl.sv
`timescale 1ns / 1ps
module rcf_ctrl #(
  parameter int ElapsedBits = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rcf_pkg::rcf_sts_t sts,
  output rcf_pkg::rcf_cmd_t cmd
);
  import rcf_pkg::*;

  localparam int NumW = ElapsedBits + 16;
  localparam int CntW = $clog2(NumW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_EV_DIV, S_EV_LOG, S_EV_POW, S_EV_E, S_EV_V, S_SEG,
    S_DIV, S_LOG, S_POW, S_E, S_V, S_HOLD
  } state_t;

  state_t state_r;
  logic [CntW-1:0] cnt_r;
  logic out_valid_r;
  logic out_free;

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Command decode
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:    cmd.load = in_valid;
      S_CHK:     begin
        cmd.div_start = sts.lvl_changed;
        cmd.acc       = !sts.lvl_changed;
      end
      S_EV_DIV:  cmd.div_step = 1'b1;
      S_EV_LOG:  cmd.log_mul = 1'b1;
      S_EV_POW:  cmd.pow_step = 1'b1;
      S_EV_E:    cmd.e_ld = 1'b1;
      S_EV_V:    cmd.vmul = 1'b1;
      S_SEG:     cmd.seg_new = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_LOG:     cmd.log_mul = 1'b1;
      S_POW:     cmd.pow_step = 1'b1;
      S_E:       cmd.e_ld = 1'b1;
      S_V:       cmd.vmul = 1'b1;
      S_HOLD:    cmd.out_ld = out_free;
      default:   cmd = '0;
    endcase
  end

  // Sequencing: a level change evaluates the old segment first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (state_r == S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE:    if (in_valid) state_r <= S_CHK;
        S_CHK:     begin
          state_r <= sts.lvl_changed ? S_EV_DIV : S_DIV;
          cnt_r   <= CntW'(NumW);
        end
        S_EV_DIV:  begin
          if (cnt_r == CntW'(1)) begin
            state_r <= S_EV_LOG;
            cnt_r   <= CntW'(16);
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_EV_LOG:  state_r <= S_EV_POW;
        S_EV_POW:  begin
          if (cnt_r == CntW'(1)) state_r <= S_EV_E;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_EV_E:    state_r <= S_EV_V;
        S_EV_V:    state_r <= S_SEG;
        S_SEG:     begin
          state_r <= S_DIV;
          cnt_r   <= CntW'(NumW);
        end
        S_DIV:     begin
          if (cnt_r == CntW'(1)) begin
            state_r <= S_LOG;
            cnt_r   <= CntW'(16);
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_LOG:     state_r <= S_POW;
        S_POW:     begin
          if (cnt_r == CntW'(1)) state_r <= S_E;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_E:       state_r <= S_V;
        S_V:       state_r <= S_HOLD;
        S_HOLD:    if (out_free) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE) && !in_stall) else $error("accept while busy");
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_HOLD) else $error("stray result");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("stalled result dropped");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !(out_valid_r && out_stall)) else $error("overrun");
endmodule

>>> src/rc_step_response_filter_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Ports
// input   | in        | in_valid, in_stall, in_level, in_time_step
// result  | out       | out_valid, out_stall, out_filtered_level
// config  | in        | cfg_valid, cfg_ready, cfg_rc_ticks
// One item at a time: a level change runs the divider and power chain for the old
// segment and then the new one, a repeated level runs them once; the result shows
// in the cycle that the next request can be taken. The bit-serial divider (one
// quotient bit a cycle) and the 16-step power chain set how long a request takes.
// Reset is synchronous, active low; rc_ticks resets to 1. A request is taken while
// a stalled result waits; the block then holds its last step until it is delivered.
module rc_step_response_filter_unit #(
  parameter int SAMPLE_BITS  = 16,
  parameter int ELAPSED_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_level,
  input  logic [15:0]                   in_time_step,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_level,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [23:0]                   cfg_rc_ticks
);
  import rcf_pkg::*;

  rcf_cmd_t cmd;
  rcf_sts_t sts;
  logic [23:0] rc_ticks_r;

  // Config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_ticks_r <= 24'd1;
    end else if (cfg_valid && cfg_ready) begin
      rc_ticks_r <= cfg_rc_ticks;
    end
  end

  rcf_ctrl #(.ElapsedBits(ELAPSED_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  rcf_datapath #(.SampleBits(SAMPLE_BITS), .ElapsedBits(ELAPSED_BITS)) u_dp (
    .clk, .cmd, .sts, .rst_n, .rc_ticks(rc_ticks_r), .in_level, .in_time_step,
    .filtered_level(out_filtered_level)
  );
endmodule
